// ===== rtl/qau_pkg.sv =====
// Shared constants, types and fixed-point helpers for the quaternion ALU.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package qau_pkg;

    // Number format: signed Q8.24 words
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int MAG_BITS  = 31;
    localparam int OP_BITS   = 4;

    // Internal widths
    localparam int PROD_BITS = 2 * WORD_BITS;          // one full product
    localparam int ACC_BITS  = PROD_BITS + 2;          // sum of four products
    localparam int SQ_BITS   = PROD_BITS + 1;          // sum of four squares
    localparam int ROOT_BITS = WORD_BITS + 1;          // floor sqrt of SQ_BITS value
    localparam int QUO_BITS  = WORD_BITS;              // quotient bits kept
    localparam int DEN_BITS  = SQ_BITS;                // widest divisor
    localparam int REM_BITS  = DEN_BITS + QUO_BITS;    // partial remainder

    // Pipeline depths
    localparam int FRONT_LAT = 4;
    localparam int DIV_LAT   = QUO_BITS + 2;
    localparam int DLY_LEN   = ROOT_BITS + DIV_LAT;
    localparam int LATENCY   = FRONT_LAT + DLY_LEN + 1;

    typedef logic [WORD_BITS-1:0]      t_word;
    typedef logic [3:0][WORD_BITS-1:0] t_quat;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [MAG_BITS-1:0] MAG_MAX = '1;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic [OP_BITS-1:0] {
        OP_CONJ      = 4'd0,
        OP_NORM      = 4'd1,
        OP_NORMALIZE = 4'd2,
        OP_INVERSE   = 4'd3,
        OP_SCALE     = 4'd4,
        OP_ADD       = 4'd5,
        OP_SUB       = 4'd6,
        OP_PRODUCT   = 4'd7,
        OP_EQUAL     = 4'd8,
        OP_NEAR      = 4'd9
    } t_op;

    // Item state that does not need the root or the divider
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        t_quat              r;
        logic               match;
        t_quat              p;
    } t_early;

    // Item state produced at the root stage
    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic                dbz;
    } t_post;

    // Sign-extend a word to accumulator width
    function automatic logic signed [ACC_BITS-1:0] sx(input t_word a);
        return $signed({{(ACC_BITS-WORD_BITS){a[WORD_BITS-1]}}, a});
    endfunction

    // Sign-extend a product to accumulator width
    function automatic logic signed [ACC_BITS-1:0] sx_prod(
        input logic [PROD_BITS-1:0] a);
        return $signed({{(ACC_BITS-PROD_BITS){a[PROD_BITS-1]}}, a});
    endfunction

    // Clamp an accumulator value to the signed word range
    function automatic t_word sat_word(input logic signed [ACC_BITS-1:0] v);
        logic [ACC_BITS-WORD_BITS:0] hi;
        hi = v[ACC_BITS-1:WORD_BITS-1];
        if (&hi || ~|hi) begin
            return v[WORD_BITS-1:0];
        end else if (v[ACC_BITS-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    // Drop the fraction bits, ties toward plus infinity, then clamp
    function automatic t_word round_sat(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] t;
        t = v + ROUND_HALF;
        return sat_word(t >>> FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qau_front.sv =====
// Front end of the quaternion ALU: input register, multipliers, sums, rounding.
// Four register stages. Depends on qau_pkg.
`default_nettype none

module qau_front import qau_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic [OP_BITS-1:0]  i_op,
    input  wire t_quat               i_p,
    input  wire t_quat               i_q,
    input  wire t_word               i_scale,
    input  wire logic [MAG_BITS-1:0] i_tol,
    output logic                     o_vld,
    output t_early                   o_early,
    output logic [SQ_BITS-1:0]       o_sumsq
);

    // Stage 1: input register
    logic               r_v1;
    logic [OP_BITS-1:0] r_op1;
    t_quat              r_p1, r_q1;
    t_word              r_f1;

    // Stage 2: products and simple ops
    logic                       r_v2;
    logic [OP_BITS-1:0]         r_op2;
    t_quat                      r_p2, r_simp2;
    logic                       r_match2;
    logic [PROD_BITS-1:0]       r_sq2   [4];
    logic signed [PROD_BITS-1:0] r_prod2 [4][4];
    logic signed [PROD_BITS-1:0] r_sc2  [4];
    t_quat                      n_simp;
    logic                       n_match;

    // Stage 3: sums
    logic                       r_v3;
    logic [OP_BITS-1:0]         r_op3;
    t_quat                      r_p3, r_simp3;
    logic                       r_match3;
    logic [SQ_BITS-1:0]         r_s3;
    logic signed [ACC_BITS-1:0] r_acc3 [4];
    logic signed [ACC_BITS-1:0] n_ham  [4];

    // Stage 4: rounded results
    logic               r_v4;
    t_early             r_e4;
    logic [SQ_BITS-1:0] r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1 <= i_op;
        r_p1  <= i_p;
        r_q1  <= i_q;
        r_f1  <= i_scale;
    end

    // Conjugate, add, subtract and compares need no multiplier
    always_comb begin
        logic signed [ACC_BITS-1:0] d;
        logic [ACC_BITS-1:0]        ad;
        n_simp  = '0;
        n_match = 1'b0;
        d       = '0;
        ad      = '0;
        case (t_op'(r_op1))
            OP_CONJ: begin
                n_simp[0] = r_p1[0];
                for (int i = 1; i < 4; i++) begin
                    n_simp[i] = sat_word(-sx(r_p1[i]));
                end
            end
            OP_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    n_simp[i] = sat_word(sx(r_p1[i]) + sx(r_q1[i]));
                end
            end
            OP_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    n_simp[i] = sat_word(sx(r_p1[i]) - sx(r_q1[i]));
                end
            end
            OP_EQUAL: begin
                n_match = (r_p1 == r_q1);
            end
            OP_NEAR: begin
                n_match = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    d  = sx(r_p1[i]) - sx(r_q1[i]);
                    ad = d[ACC_BITS-1] ? -d : d;
                    if (ad >= ACC_BITS'(i_tol)) begin
                        n_match = 1'b0;
                    end
                end
            end
            default: begin
                n_match = 1'b0;
            end
        endcase
    end

    // Multiplier bank: squares of p, all p*q cross terms, scale*p
    always_ff @(posedge i_clk) begin
        r_op2    <= r_op1;
        r_p2     <= r_p1;
        r_simp2  <= n_simp;
        r_match2 <= n_match;
        for (int j = 0; j < 4; j++) begin
            r_sq2[j] <= $signed(r_p1[j]) * $signed(r_p1[j]);
            r_sc2[j] <= $signed(r_f1) * $signed(r_p1[j]);
            for (int k = 0; k < 4; k++) begin
                r_prod2[j][k] <= $signed(r_p1[j]) * $signed(r_q1[k]);
            end
        end
    end

    // Hamilton product sums
    always_comb begin
        n_ham[0] = sx_prod(r_prod2[0][0]) - sx_prod(r_prod2[1][1])
                 - sx_prod(r_prod2[2][2]) - sx_prod(r_prod2[3][3]);
        n_ham[1] = sx_prod(r_prod2[0][1]) + sx_prod(r_prod2[1][0])
                 + sx_prod(r_prod2[2][3]) - sx_prod(r_prod2[3][2]);
        n_ham[2] = sx_prod(r_prod2[0][2]) + sx_prod(r_prod2[2][0])
                 + sx_prod(r_prod2[3][1]) - sx_prod(r_prod2[1][3]);
        n_ham[3] = sx_prod(r_prod2[0][3]) + sx_prod(r_prod2[1][2])
                 + sx_prod(r_prod2[3][0]) - sx_prod(r_prod2[2][1]);
    end

    always_ff @(posedge i_clk) begin
        r_op3    <= r_op2;
        r_p3     <= r_p2;
        r_simp3  <= r_simp2;
        r_match3 <= r_match2;
        r_s3     <= SQ_BITS'(r_sq2[0]) + SQ_BITS'(r_sq2[1])
                  + SQ_BITS'(r_sq2[2]) + SQ_BITS'(r_sq2[3]);
        for (int i = 0; i < 4; i++) begin
            r_acc3[i] <= (r_op2 == OP_SCALE) ? sx_prod(r_sc2[i]) : n_ham[i];
        end
    end

    // Round scale and product sums back to Q format; other ops keep the simple result
    always_ff @(posedge i_clk) begin
        r_e4.op    <= r_op3;
        r_e4.p     <= r_p3;
        r_e4.match <= r_match3;
        r_s4       <= r_s3;
        for (int i = 0; i < 4; i++) begin
            r_e4.r[i] <= (r_op3 == OP_SCALE || r_op3 == OP_PRODUCT)
                       ? round_sat(r_acc3[i]) : r_simp3[i];
        end
    end

    assign o_vld   = r_v4;
    assign o_early = r_e4;
    assign o_sumsq = r_s4;

endmodule

`default_nettype wire

// ===== rtl/qau_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries the radicand along. Depends on qau_pkg.
`default_nettype none

module qau_sqrt import qau_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic [SQ_BITS-1:0]   i_sumsq,
    output logic                      o_vld,
    output logic [ROOT_BITS-1:0]      o_root,
    output logic [SQ_BITS-1:0]        o_sumsq
);

    localparam int RMW = SQ_BITS + 2;

    logic                 s_vld  [0:ROOT_BITS];
    logic [RMW-1:0]       s_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] s_root [0:ROOT_BITS];
    logic [SQ_BITS-1:0]   s_sum  [0:ROOT_BITS];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = RMW'(i_sumsq);
    assign s_root[0] = '0;
    assign s_sum[0]  = i_sumsq;

    // Stage k decides root bit B; rem holds radicand minus root squared
    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        localparam int B = ROOT_BITS - 1 - k;
        logic                 r_vld;
        logic [RMW-1:0]       r_rem;
        logic [ROOT_BITS-1:0] r_root;
        logic [SQ_BITS-1:0]   r_sum;
        logic [RMW-1:0]       w_trial;
        logic                 w_take;

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign w_trial = (RMW'(s_root[k]) << (B + 1)) | (RMW'(1) << (2 * B));
        assign w_take  = (s_rem[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= w_take ? (s_rem[k] - w_trial) : s_rem[k];
            r_root <= w_take ? (s_root[k] | (ROOT_BITS'(1) << B)) : s_root[k];
            r_sum  <= s_sum[k];
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_sum[k+1]  = r_sum;
    end

    assign o_vld   = s_vld[ROOT_BITS];
    assign o_root  = s_root[ROOT_BITS];
    assign o_sumsq = s_sum[ROOT_BITS];

endmodule

`default_nettype wire

// ===== rtl/qau_div.sv =====
// Pipelined restoring divider for one component, one quotient bit per stage,
// with overflow check and signed saturation of the result. Depends on qau_pkg.
`default_nettype none

module qau_div import qau_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic [REM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    input  wire logic                i_neg,
    output logic                     o_vld,
    output t_word                    o_res
);

    // Input register
    logic                r_a_vld;
    logic [REM_BITS-1:0] r_a_num;
    logic [DEN_BITS-1:0] r_a_den;
    logic                r_a_neg;

    // Overflow stage: quotient would not fit in QUO_BITS
    logic                r_b_vld;
    logic [REM_BITS-1:0] r_b_rem;
    logic [DEN_BITS-1:0] r_b_den;
    logic                r_b_neg;
    logic                r_b_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_num <= i_num;
        r_a_den <= i_den;
        r_a_neg <= i_neg;
        r_b_rem <= r_a_num;
        r_b_den <= r_a_den;
        r_b_neg <= r_a_neg;
        r_b_ovf <= (r_a_num >= (REM_BITS'(r_a_den) << QUO_BITS));
    end

    logic                s_vld [0:QUO_BITS];
    logic [REM_BITS-1:0] s_rem [0:QUO_BITS];
    logic [DEN_BITS-1:0] s_den [0:QUO_BITS];
    logic [QUO_BITS-1:0] s_quo [0:QUO_BITS];
    logic                s_neg [0:QUO_BITS];
    logic                s_ovf [0:QUO_BITS];

    assign s_vld[0] = r_b_vld;
    assign s_rem[0] = r_b_rem;
    assign s_den[0] = r_b_den;
    assign s_quo[0] = '0;
    assign s_neg[0] = r_b_neg;
    assign s_ovf[0] = r_b_ovf;

    // Stage k decides quotient bit B
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        localparam int B = QUO_BITS - 1 - k;
        logic                r_vld;
        logic [REM_BITS-1:0] r_rem;
        logic [DEN_BITS-1:0] r_den;
        logic [QUO_BITS-1:0] r_quo;
        logic                r_neg;
        logic                r_ovf;
        logic [REM_BITS-1:0] w_trial;
        logic                w_take;

        assign w_trial = REM_BITS'(s_den[k]) << B;
        assign w_take  = (s_rem[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= w_take ? (s_rem[k] - w_trial) : s_rem[k];
            r_quo <= w_take ? (s_quo[k] | (QUO_BITS'(1) << B)) : s_quo[k];
            r_den <= s_den[k];
            r_neg <= s_neg[k];
            r_ovf <= s_ovf[k];
        end

        assign s_vld[k+1] = r_vld;
        assign s_rem[k+1] = r_rem;
        assign s_den[k+1] = r_den;
        assign s_quo[k+1] = r_quo;
        assign s_neg[k+1] = r_neg;
        assign s_ovf[k+1] = r_ovf;
    end

    // Apply sign and clamp to the word range
    always_comb begin
        if (s_neg[QUO_BITS]) begin
            if (s_ovf[QUO_BITS] || s_quo[QUO_BITS] > QUO_BITS'(WORD_MIN)) begin
                o_res = WORD_MIN;
            end else begin
                o_res = t_word'(-s_quo[QUO_BITS]);
            end
        end else begin
            if (s_ovf[QUO_BITS] || s_quo[QUO_BITS][QUO_BITS-1]) begin
                o_res = WORD_MAX;
            end else begin
                o_res = t_word'(s_quo[QUO_BITS]);
            end
        end
    end

    assign o_vld = s_vld[QUO_BITS];

endmodule

`default_nettype wire

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Top level of the quaternion ALU: tolerance register, front end, square root,
// four dividers, side delay lines and output register. Depends on qau_pkg.
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. busy is never raised, so one item may be issued every cycle.
//   Result channel: o_done is high for exactly one cycle per item, with the result on
//   o_r_*, o_magnitude, o_match and o_divide_by_zero; the receiver cannot stall.
//   Every operation passes from accept to o_done through 4 front stages (input,
//   multipliers, sums, rounding), 33 root stages (one bit each), 34 divider
//   stages (input, overflow check, one quotient bit each) and the output
//   register. Throughput is one item per cycle.
//   Tolerance: i_tol_we writes i_tol_data; write it only while no item is in
//   flight. Reset value 256.
//   Reset (synchronous, active low) drops every item in flight and restores the
//   tolerance; o_done stays low until a new item has passed the pipeline.
`default_nettype none

module quaternion_arithmetic_unit import qau_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_BITS-1:0]  i_operation,
    input  wire t_word               i_p_w,
    input  wire t_word               i_p_x,
    input  wire t_word               i_p_y,
    input  wire t_word               i_p_z,
    input  wire t_word               i_q_w,
    input  wire t_word               i_q_x,
    input  wire t_word               i_q_y,
    input  wire t_word               i_q_z,
    input  wire t_word               i_scale,
    input  wire logic                i_tol_we,
    input  wire logic [MAG_BITS-1:0] i_tol_data,
    output logic                     o_done,
    output t_word                    o_r_w,
    output t_word                    o_r_x,
    output t_word                    o_r_y,
    output t_word                    o_r_z,
    output logic [MAG_BITS-1:0]      o_magnitude,
    output logic                     o_match,
    output logic                     o_divide_by_zero
);

    logic [MAG_BITS-1:0] r_tolerance;

    logic               f_vld;
    t_early             f_early;
    logic [SQ_BITS-1:0] f_sumsq;

    logic                 sq_vld;
    logic [ROOT_BITS-1:0] sq_root;
    logic [SQ_BITS-1:0]   sq_sumsq;

    t_early r_dly  [DLY_LEN];
    t_post  r_mdly [DIV_LAT];
    t_early e_tap, e_end;
    t_post  n_post;

    logic [REM_BITS-1:0] n_num [4];
    logic [DEN_BITS-1:0] n_den [4];
    logic                n_neg [4];
    logic                d_vld [4];
    t_word               d_res [4];

    logic  r_done;
    t_quat r_res;
    logic [MAG_BITS-1:0] r_mag;
    logic  r_match;
    logic  r_dbz;
    logic  w_use_div;

    assign busy = 1'b0;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= MAG_BITS'(256);
        end else if (i_tol_we) begin
            r_tolerance <= i_tol_data;
        end
    end

    qau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_op    (i_operation),
        .i_p     ({i_p_z, i_p_y, i_p_x, i_p_w}),
        .i_q     ({i_q_z, i_q_y, i_q_x, i_q_w}),
        .i_scale (i_scale),
        .i_tol   (r_tolerance),
        .o_vld   (f_vld),
        .o_early (f_early),
        .o_sumsq (f_sumsq)
    );

    qau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_sumsq (f_sumsq),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_sumsq (sq_sumsq)
    );

    // Side delay lines, aligned with the root and divider pipelines
    always_ff @(posedge i_clk) begin
        r_dly[0] <= f_early;
        for (int i = 1; i < DLY_LEN; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
        r_mdly[0] <= n_post;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_mdly[i] <= r_mdly[i-1];
        end
    end

    assign e_tap = r_dly[ROOT_BITS-1];
    assign e_end = r_dly[DLY_LEN-1];

    // Magnitude and zero check at the root output
    always_comb begin
        n_post.dbz = (e_tap.op == OP_NORMALIZE || e_tap.op == OP_INVERSE)
                   && (sq_sumsq == '0);
        if (e_tap.op != OP_NORM) begin
            n_post.mag = '0;
        end else if (sq_root > ROOT_BITS'(MAG_MAX)) begin
            n_post.mag = MAG_MAX;
        end else begin
            n_post.mag = sq_root[MAG_BITS-1:0];
        end
    end

    // Rounded quotient operands: normalize divides p by the root,
    // inverse divides conj(p) by the sum of squares
    always_comb begin
        logic  inv;
        t_word pc;
        t_word mag;
        inv = (e_tap.op == OP_INVERSE);
        pc  = '0;
        mag = '0;
        for (int i = 0; i < 4; i++) begin
            pc  = e_tap.p[i];
            mag = pc[WORD_BITS-1] ? t_word'(-pc) : pc;
            if (inv) begin
                n_num[i] = (REM_BITS'(mag) << (2 * FRAC_BITS))
                         + REM_BITS'(sq_sumsq >> 1);
                n_den[i] = sq_sumsq;
                n_neg[i] = (i == 0) ? pc[WORD_BITS-1]
                                    : (!pc[WORD_BITS-1] && pc != '0);
            end else begin
                n_num[i] = (REM_BITS'(mag) << FRAC_BITS) + REM_BITS'(sq_root >> 1);
                n_den[i] = DEN_BITS'(sq_root);
                n_neg[i] = pc[WORD_BITS-1];
            end
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_div
        qau_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sq_vld),
            .i_num   (n_num[i]),
            .i_den   (n_den[i]),
            .i_neg   (n_neg[i]),
            .o_vld   (d_vld[i]),
            .o_res   (d_res[i])
        );
    end

    assign w_use_div = (e_end.op == OP_NORMALIZE || e_end.op == OP_INVERSE)
                     && !r_mdly[DIV_LAT-1].dbz;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_vld[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_res[i] <= w_use_div ? d_res[i] : e_end.r[i];
            end
            r_mag   <= r_mdly[DIV_LAT-1].mag;
            r_dbz   <= r_mdly[DIV_LAT-1].dbz;
            r_match <= e_end.match;
        end
    end

    assign o_done           = r_done;
    assign o_r_w            = r_res[0];
    assign o_r_x            = r_res[1];
    assign o_r_y            = r_res[2];
    assign o_r_z            = r_res[3];
    assign o_magnitude      = r_mag;
    assign o_match          = r_match;
    assign o_divide_by_zero = r_dbz;

endmodule

`default_nettype wire

// ===== rtl/qau_checker.sv =====
// Port-level checks for the quaternion ALU and the bind that attaches them.
// Depends on qau_pkg and quaternion_arithmetic_unit.
`default_nettype none

module qau_checker import qau_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_done,
    input wire t_word               o_r_w,
    input wire t_word               o_r_x,
    input wire t_word               o_r_y,
    input wire t_word               o_r_z,
    input wire logic [MAG_BITS-1:0] o_magnitude,
    input wire logic                o_match,
    input wire logic                o_divide_by_zero
);

    // Every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_done)
        else $error("item did not complete after fixed latency");

    // No result without a matching accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without accepted item");

    // Divide by zero gives an all-zero result
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_divide_by_zero |-> o_r_w == '0 && o_r_x == '0 && o_r_y == '0
            && o_r_z == '0 && !o_match && o_magnitude == '0)
        else $error("divide by zero with nonzero result");

    // A norm result carries no quaternion and no match
    a_norm_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_magnitude != '0 |-> o_r_w == '0 && o_r_x == '0
            && o_r_y == '0 && o_r_z == '0 && !o_match)
        else $error("magnitude with other result fields set");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);

`default_nettype wire

// ===== verif/quaternion_arithmetic_unit_test.sv =====
// Self-checking testbench for the quaternion ALU: directed and random items,
// tolerance changes between phases, one result checked per item in order.
// Depends on qau_pkg and quaternion_arithmetic_unit.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_test;
    import qau_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_word               r_w, r_x, r_y, r_z;
        logic [MAG_BITS-1:0] mag;
        logic                match;
        logic                dbz;
    } t_expect;

    localparam t_wide W_MAX     = 128'sd2147483647;
    localparam t_wide W_MIN     = -128'sd2147483648;
    localparam t_word ONE_Q     = 32'h0100_0000;
    localparam int    RUN_LIMIT = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_BITS-1:0]  i_operation = '0;
    t_word               i_p_w = '0, i_p_x = '0, i_p_y = '0, i_p_z = '0;
    t_word               i_q_w = '0, i_q_x = '0, i_q_y = '0, i_q_z = '0;
    t_word               i_scale = '0;
    logic                i_tol_we = 1'b0;
    logic [MAG_BITS-1:0] i_tol_data = '0;
    logic                o_done;
    t_word               o_r_w, o_r_x, o_r_y, o_r_z;
    logic [MAG_BITS-1:0] o_magnitude;
    logic                o_match, o_divide_by_zero;

    t_expect             pending_results[$];
    logic [MAG_BITS-1:0] tolerance_cfg = 31'd256;
    int                  gap_pct = 0;
    int                  fail_count = 0;
    int                  cycle_count = 0;

    quaternion_arithmetic_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- fixed-point predictor ----------------
    function automatic t_wide widen(t_word a);
        t_wide v;
        v = $signed(a);
        return v;
    endfunction

    function automatic t_word clamp_word(t_wide v);
        if (v > W_MAX) return WORD_MAX;
        if (v < W_MIN) return WORD_MIN;
        return v[WORD_BITS-1:0];
    endfunction

    function automatic t_word round_product(t_wide v);
        t_wide t;
        t = (v + (t_wide'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return clamp_word(t);
    endfunction

    function automatic t_wide floor_root(t_wide s);
        t_wide r, t;
        r = 0;
        for (int b = 32; b >= 0; b--) begin
            t = r | (t_wide'(1) <<< b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    // Nearest quotient, ties away from zero
    function automatic t_word round_quotient(t_wide num, int shift, t_wide den);
        t_wide m, qv;
        m = (num < 0) ? -num : num;
        qv = ((m <<< shift) + (den >>> 1)) / den;
        return clamp_word((num < 0) ? -qv : qv);
    endfunction

    function automatic t_expect compute_result(logic [OP_BITS-1:0] op, t_quat p, t_quat q,
                                               t_word f, logic [MAG_BITS-1:0] tol);
        t_expect e;
        t_wide   pw[4], qw[4], rr[4], sq, root, d;
        e = '{default: '0};
        rr = '{default: 0};
        sq = 0;
        for (int i = 0; i < 4; i++) begin
            pw[i] = widen(p[i]);
            qw[i] = widen(q[i]);
            sq += pw[i] * pw[i];
        end
        case (op)
            OP_CONJ: begin
                rr[0] = pw[0];
                for (int i = 1; i < 4; i++) rr[i] = -pw[i];
            end
            OP_NORM: begin
                root = floor_root(sq);
                e.mag = (root > W_MAX) ? MAG_MAX : root[MAG_BITS-1:0];
            end
            OP_NORMALIZE, OP_INVERSE: begin
                // zero quaternion raises the flag and gives zeros
                if (sq == 0) begin
                    e.dbz = 1'b1;
                end else begin
                    root = floor_root(sq);
                    for (int i = 0; i < 4; i++) begin
                        if (op == OP_NORMALIZE)
                            rr[i] = widen(round_quotient(pw[i], FRAC_BITS, root));
                        else
                            rr[i] = widen(round_quotient((i == 0) ? pw[i] : -pw[i],
                                                         2 * FRAC_BITS, sq));
                    end
                end
            end
            OP_SCALE: for (int i = 0; i < 4; i++)
                rr[i] = widen(round_product(widen(f) * pw[i]));
            OP_ADD: for (int i = 0; i < 4; i++) rr[i] = pw[i] + qw[i];
            OP_SUB: for (int i = 0; i < 4; i++) rr[i] = pw[i] - qw[i];
            OP_PRODUCT: begin
                rr[0] = widen(round_product(pw[0]*qw[0] - pw[1]*qw[1]
                                            - pw[2]*qw[2] - pw[3]*qw[3]));
                rr[1] = widen(round_product(pw[0]*qw[1] + pw[1]*qw[0]
                                            + pw[2]*qw[3] - pw[3]*qw[2]));
                rr[2] = widen(round_product(pw[0]*qw[2] + pw[2]*qw[0]
                                            + pw[3]*qw[1] - pw[1]*qw[3]));
                rr[3] = widen(round_product(pw[0]*qw[3] + pw[1]*qw[2]
                                            + pw[3]*qw[0] - pw[2]*qw[1]));
            end
            OP_EQUAL: begin
                e.match = 1'b1;
                for (int i = 0; i < 4; i++) if (pw[i] != qw[i]) e.match = 1'b0;
            end
            OP_NEAR: begin
                e.match = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    d = pw[i] - qw[i];
                    if (d < 0) d = -d;
                    if (d >= t_wide'(tol)) e.match = 1'b0;
                end
            end
            default: ;
        endcase
        e.r_w = clamp_word(rr[0]);
        e.r_x = clamp_word(rr[1]);
        e.r_y = clamp_word(rr[2]);
        e.r_z = clamp_word(rr[3]);
        return e;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_r_w !== e.r_w) begin
                    $error("r_w exp %h got %h", e.r_w, o_r_w); fail_count++;
                end
                if (o_r_x !== e.r_x) begin
                    $error("r_x exp %h got %h", e.r_x, o_r_x); fail_count++;
                end
                if (o_r_y !== e.r_y) begin
                    $error("r_y exp %h got %h", e.r_y, o_r_y); fail_count++;
                end
                if (o_r_z !== e.r_z) begin
                    $error("r_z exp %h got %h", e.r_z, o_r_z); fail_count++;
                end
                if (o_magnitude !== e.mag) begin
                    $error("magnitude exp %h got %h", e.mag, o_magnitude); fail_count++;
                end
                if (o_match !== e.match) begin
                    $error("match exp %b got %b", e.match, o_match); fail_count++;
                end
                if (o_divide_by_zero !== e.dbz) begin
                    $error("divide_by_zero exp %b got %b", e.dbz, o_divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    // Sends one item, with a random gap first; returns at the accepting edge
    task automatic send_item(logic [OP_BITS-1:0] op, t_quat p, t_quat q, t_word f);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_p_w <= p[0]; i_p_x <= p[1]; i_p_y <= p[2]; i_p_z <= p[3];
        i_q_w <= q[0]; i_q_x <= q[1]; i_q_y <= q[2]; i_q_z <= q[3];
        i_scale <= f;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending_results.push_back(compute_result(op, p, q, f, tolerance_cfg));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_tolerance(logic [MAG_BITS-1:0] v);
        drain();
        i_tol_we   <= 1'b1;
        i_tol_data <= v;
        @(posedge i_clk);
        i_tol_we <= 1'b0;
        tolerance_cfg = v;
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return t_word'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            4: return $urandom_range(1) ? ONE_Q : -ONE_Q;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_item();
        logic [OP_BITS-1:0] op;
        t_quat p, q;
        t_word f;
        op = ($urandom_range(19) == 0) ? OP_BITS'($urandom_range(10, 15))
                                       : OP_BITS'($urandom_range(0, 9));
        for (int i = 0; i < 4; i++) begin
            p[i] = pick_word();
            q[i] = pick_word();
        end
        f = pick_word();
        if ((op == OP_NORMALIZE || op == OP_INVERSE) && $urandom_range(7) == 0) p = '0;
        // comparisons: mostly operands that are equal or close
        if ((op == OP_EQUAL || op == OP_NEAR) && $urandom_range(3) != 0) begin
            for (int i = 0; i < 4; i++)
                q[i] = ($urandom_range(1) && op == OP_EQUAL) ? p[i] :
                       p[i] + t_word'($signed($urandom_range(0, 2 * tolerance_cfg[15:0] + 2))
                                      - $signed(tolerance_cfg[15:0]) - 1);
        end
        send_item(op, p, q, f);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        t_quat z, mx, mn, one;
        z = '0;
        mx = {4{WORD_MAX}};
        mn = {4{WORD_MIN}};
        one = '0; one[0] = ONE_Q;
        for (int op = 0; op < 16; op++) send_item(OP_BITS'(op), mx, mn, WORD_MAX);
        for (int op = 0; op < 10; op++) send_item(OP_BITS'(op), mn, mx, WORD_MIN);
        send_item(OP_NORMALIZE, z, z, '0);          // zero quaternion
        send_item(OP_INVERSE, z, z, '0);
        send_item(OP_CONJ, mn, z, '0);              // negate most negative
        send_item(OP_INVERSE, {{3{32'h0}}, 32'h1}, z, '0);  // tiny input saturates
        send_item(OP_PRODUCT, one, one, ONE_Q);
        send_item(OP_EQUAL, one, one, '0);
        send_item(OP_NEAR, one, {one[3:1], ONE_Q + 32'd255}, '0);
        send_item(OP_NEAR, one, {one[3:1], ONE_Q + 32'd256}, '0);
        drain();
    endtask

    task automatic test_tolerance_extremes();
        t_quat p;
        p = {WORD_MAX, WORD_MIN, 32'h0, ONE_Q};
        set_tolerance('0);
        send_item(OP_NEAR, p, p, '0);
        set_tolerance(MAG_MAX);
        send_item(OP_NEAR, p, {WORD_MIN, WORD_MAX, 32'h0, ONE_Q}, '0);
        send_item(OP_NEAR, p, {WORD_MAX, WORD_MIN, 32'h7FFF_FFFF, ONE_Q}, '0);
        drain();
    endtask

    task automatic test_random(int sender_gap);
        gap_pct = sender_gap;
        set_tolerance($urandom_range(1) ? MAG_BITS'($urandom)
                                        : MAG_BITS'($urandom_range(0, 4096)));
        repeat (170) send_random_item();
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_tolerance_extremes();
        test_random(15);
        test_random(77);
        test_random(0);
        set_tolerance(31'd256);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qau_pkg.sv
rtl/qau_front.sv
rtl/qau_sqrt.sv
rtl/qau_div.sv
rtl/quaternion_arithmetic_unit.sv
rtl/qau_checker.sv
verif/quaternion_arithmetic_unit_test.sv
